// ===== hw/rtl/pfc_pkg.sv =====
// Shared types, constants and helper functions for the Playfair digraph cipher.
package pfc_pkg;

  // Square geometry and letter coding.
  localparam int SIDE        = 5;
  localparam int CELLS       = SIDE * SIDE;
  localparam int NUM_LETTERS = 26;
  localparam int LETTER_W    = 5;
  localparam int RC_W        = $clog2(SIDE);
  localparam int IDX_W       = $clog2(CELLS);
  localparam int FILL_W      = $clog2(CELLS + 1);

  localparam logic [LETTER_W-1:0] CODE_I = LETTER_W'(8);
  localparam logic [LETTER_W-1:0] CODE_J = LETTER_W'(9);
  localparam logic [LETTER_W-1:0] CODE_Z = LETTER_W'(25);

  // Command codes carried by an input item.
  typedef enum logic [2:0] {
    CMD_BEGIN    = 3'd0,
    CMD_KEY      = 3'd1,
    CMD_COMPLETE = 3'd2,
    CMD_ENCRYPT  = 3'd3,
    CMD_DECRYPT  = 3'd4
  } cmd_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS,
    ST_SQ,
    ST_OUT
  } state_e;

  // Status codes of a result item.
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [LETTER_W-1:0] letter_a;
    logic [LETTER_W-1:0] letter_b;
  } req_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_a;
    logic [LETTER_W-1:0] out_b;
    logic                status;
  } rsp_t;

  // Position of a letter in the square.
  typedef struct packed {
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } pos_t;

  // Candidate cell indexes that one lane offers to the merge.
  typedef struct packed {
    logic [IDX_W-1:0] shift_col;
    logic [IDX_W-1:0] shift_row;
    logic [IDX_W-1:0] swap;
  } lane_cand_t;

  // Clamp codes above Z to Z and fold J onto I.
  function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] v);
    logic [LETTER_W-1:0] c;
    c = (v > CODE_Z) ? CODE_Z : v;
    if (c == CODE_J) begin
      c = CODE_I;
    end
    return c;
  endfunction

  // Step a row or column one place forward (encrypt) or back (decrypt), wrapping.
  function automatic logic [RC_W-1:0] step_coord(input logic [RC_W-1:0] c,
                                                 input logic             back);
    logic [RC_W-1:0] r;
    if (back) begin
      r = (c == '0) ? RC_W'(SIDE - 1) : RC_W'(c - 1'b1);
    end else begin
      r = (c == RC_W'(SIDE - 1)) ? '0 : RC_W'(c + 1'b1);
    end
    return r;
  endfunction

  // Row-major cell index of a position.
  function automatic logic [IDX_W-1:0] cell_index(input logic [RC_W-1:0] row,
                                                  input logic [RC_W-1:0] col);
    logic [IDX_W-1:0] r;
    r = IDX_W'(row);
    return IDX_W'(r * IDX_W'(SIDE) + IDX_W'(col));
  endfunction

endpackage

// ===== hw/rtl/pfc_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module pfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== hw/rtl/pfc_lane.sv =====
// One cipher lane: the candidate output cells for one letter of the pair.
module pfc_lane import pfc_pkg::*; (
  input  pos_t       own,
  input  pos_t       peer,
  input  logic       decrypt,
  output lane_cand_t cand
);

  logic [RC_W-1:0] row_step;
  logic [RC_W-1:0] col_step;

  // Wrapped steps along the row and along the column.
  always_comb begin
    row_step = step_coord(own.row, decrypt);
    col_step = step_coord(own.col, decrypt);
  end

  // Same-row, same-column and rectangle candidates.
  always_comb begin
    cand.shift_col = cell_index(own.row, col_step);
    cand.shift_row = cell_index(row_step, own.col);
    cand.swap      = cell_index(own.row, peer.col);
  end

endmodule

// ===== hw/rtl/playfair_digraph_cipher.sv =====
// Top level of the Playfair digraph cipher: key sequencer, lanes, merge and output register.
//
//  Channel | Signals                    | Payload fields
//  --------+----------------------------+-----------------------------
//  request | req_valid, req_ready, req  | cmd, letter_a, letter_b
//  result  | rsp_valid, rsp_ready, rsp  | out_a, out_b, status
//
// Begin key and key letter items are taken in the idle state. After its accept, Complete
// feeds one letter code per cycle for 26 codes through the fill sequencer. A cipher pair
// steps through accept, letter-to-position RAM read, square RAM read, output register load;
// a pair issued before the square is ready goes from accept straight to the output load.
// Reset clears the control state only; the square needs no clearing pass. A result waits in
// the output register while the next item is taken; a finished pair holds until it is free.
module playfair_digraph_cipher import pfc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_e               state;
  state_e               state_next;
  logic [NUM_LETTERS-1:0] used_map;
  logic [FILL_W-1:0]    fill_count;
  logic [RC_W-1:0]      fill_row;
  logic [RC_W-1:0]      fill_col;
  logic                 square_ready;
  logic [LETTER_W-1:0]  fill_letter;
  logic                 decrypt;
  rsp_t                 res;

  logic                 req_fire;
  cmd_e                 cmd;
  logic                 app_req;
  logic [LETTER_W-1:0]  app_letter;
  logic                 app_we;
  logic                 load_out;
  logic                 fill_last;
  logic                 square_full;

  logic [LETTER_W-1:0]  fold_a;
  logic [LETTER_W-1:0]  fold_b;
  pos_t                 pos_a;
  pos_t                 pos_b;
  lane_cand_t           cand_a;
  lane_cand_t           cand_b;
  logic                 same_row;
  logic                 same_col;
  logic [IDX_W-1:0]     sq_addr_a;
  logic [IDX_W-1:0]     sq_addr_b;
  logic [LETTER_W-1:0]  sq_data_a;
  logic [LETTER_W-1:0]  sq_data_b;

  assign cmd         = cmd_e'(req.cmd);
  assign req_fire    = req_valid && req_ready;
  assign fold_a      = fold_letter(req.letter_a);
  assign fold_b      = fold_letter(req.letter_b);
  assign fill_last   = (fill_letter == LETTER_W'(NUM_LETTERS - 1));
  assign square_full = (fill_count == FILL_W'(CELLS));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (cmd)
            CMD_COMPLETE: state_next = ST_FILL;
            CMD_ENCRYPT,
            CMD_DECRYPT:  state_next = square_ready ? ST_POS : ST_OUT;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_POS:  state_next = ST_SQ;
      ST_SQ:   state_next = ST_OUT;
      ST_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs: handshake, letter append request and output load.
  always_comb begin
    req_ready  = 1'b0;
    app_req    = 1'b0;
    app_letter = fold_a;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        app_req   = req_fire && (cmd == CMD_KEY) && (req.letter_a <= CODE_Z);
      end
      ST_FILL: begin
        app_letter = fill_letter;
        app_req    = (fill_letter != CODE_J);
      end
      ST_OUT: begin
        load_out = !rsp_valid || rsp_ready;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // A letter enters the square only if it is new and there is room.
  assign app_we = app_req && !used_map[app_letter] && !square_full;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      used_map     <= '0;
      fill_count   <= '0;
      fill_row     <= '0;
      fill_col     <= '0;
      square_ready <= 1'b0;
      fill_letter  <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (req_fire && (cmd == CMD_BEGIN)) begin
        used_map     <= '0;
        fill_count   <= '0;
        fill_row     <= '0;
        fill_col     <= '0;
        square_ready <= 1'b0;
      end else if (app_we) begin
        used_map[app_letter] <= 1'b1;
        fill_count           <= FILL_W'(fill_count + 1'b1);
        if (fill_col == RC_W'(SIDE - 1)) begin
          fill_col <= '0;
          fill_row <= RC_W'(fill_row + 1'b1);
        end else begin
          fill_col <= RC_W'(fill_col + 1'b1);
        end
      end
      if (state == ST_FILL) begin
        fill_letter <= fill_last ? '0 : LETTER_W'(fill_letter + 1'b1);
        if (fill_last) begin
          square_ready <= 1'b1;
        end
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Pair datapath registers.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      decrypt <= (cmd == CMD_DECRYPT);
      res     <= '{out_a: '0, out_b: '0, status: STATUS_NOT_READY};
    end
    if (state == ST_SQ) begin
      res <= '{out_a: sq_data_a, out_b: sq_data_b, status: STATUS_OK};
    end
    if (load_out) begin
      rsp <= res;
    end
  end

  // Letter-to-position table, written as each letter enters the square.
  pfc_ram #(
    .WIDTH ($bits(pos_t)),
    .DEPTH (NUM_LETTERS)
  ) u_pos_ram (
    .clk    (clk),
    .we     (app_we),
    .waddr  (app_letter),
    .wdata  ({fill_row, fill_col}),
    .raddr0 (fold_a),
    .raddr1 (fold_b),
    .rdata0 (pos_a),
    .rdata1 (pos_b)
  );

  // One lane per letter of the pair.
  pfc_lane u_lane_a (
    .own     (pos_a),
    .peer    (pos_b),
    .decrypt (decrypt),
    .cand    (cand_a)
  );

  pfc_lane u_lane_b (
    .own     (pos_b),
    .peer    (pos_a),
    .decrypt (decrypt),
    .cand    (cand_b)
  );

  // Merge: pick the rule from the two positions; same row wins over same column.
  always_comb begin
    same_row = (pos_a.row == pos_b.row);
    same_col = (pos_a.col == pos_b.col);
    if (same_row) begin
      sq_addr_a = cand_a.shift_col;
      sq_addr_b = cand_b.shift_col;
    end else if (same_col) begin
      sq_addr_a = cand_a.shift_row;
      sq_addr_b = cand_b.shift_row;
    end else begin
      sq_addr_a = cand_a.swap;
      sq_addr_b = cand_b.swap;
    end
  end

  // The key square itself, row-major.
  pfc_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (CELLS)
  ) u_square_ram (
    .clk    (clk),
    .we     (app_we),
    .waddr  (fill_count[IDX_W-1:0]),
    .wdata  (app_letter),
    .raddr0 (sq_addr_a),
    .raddr1 (sq_addr_b),
    .rdata0 (sq_data_a),
    .rdata1 (sq_data_b)
  );

  // Every used letter occupies exactly one filled cell.
  a_used_matches_fill: assert property (@(posedge clk) disable iff (rst)
    $countones(used_map) == 32'(fill_count))
    else $error("used map and fill count disagree");

  // A ready square is always completely filled.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    square_ready |-> square_full)
    else $error("square marked ready while not full");

  // J never enters the square.
  a_no_j: assert property (@(posedge clk) disable iff (rst)
    app_we |-> (app_letter != CODE_J))
    else $error("letter J written to the square");

  // Position lookups only happen on a ready square.
  a_pos_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POS) |-> square_ready)
    else $error("pair processed on a square that is not ready");

  // After the position lookup, a pair passes the square read and then reaches the output state.
  a_pair_latency: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POS) |=> ##1 (state == ST_OUT))
    else $error("pair pipeline out of step");

endmodule
